// ===== rtl/core/tisd_pkg.sv =====
`timescale 1ns / 1ps

package tisd_pkg;

	// result kinds
	localparam logic [1:0] KIND_MAP    = 2'd0;
	localparam logic [1:0] KIND_RGB    = 2'd1;
	localparam logic [1:0] KIND_INDEX  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
	localparam logic [2:0] ST_MAP_INDEX = 3'd2;
	localparam logic [2:0] ST_PIX_SIZE  = 3'd3;
	localparam logic [2:0] ST_EARLY_END = 3'd4;

	// packed stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tisd_rgb_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] map_entry;
		logic [7:0]  color_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [15:0] column;
		logic [7:0]  run_length;
		logic        top_first;
		logic [2:0]  status;
		logic        image_done;
	} tisd_result_t;

	// row/column wrap unit result
	typedef struct packed {
		logic        valid;
		logic        busy;
		logic [7:0]  quot;
		logic [15:0] rem;
	} tisd_wrap_t;

	// convert 1..4 stored bytes (low byte first) into a color
	function automatic tisd_rgb_t tisd_to_rgb(input logic [4:0] size, input logic [23:0] pix);
		tisd_rgb_t c;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = pix[7:0];
		b1 = pix[15:8];
		b2 = pix[23:16];
		if (size == 5'd1) begin
			c.red   = b0;
			c.green = b0;
			c.blue  = b0;
		end else if (size == 5'd2) begin
			c.red   = {b1[6:2], 3'b000};
			c.green = {b1[1:0], b0[7:5], 3'b000};
			c.blue  = {b0[4:0], 3'b000};
		end else begin
			c.red   = b2;
			c.green = b1;
			c.blue  = b0;
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/tisd_in_reg.sv =====
`timescale 1ns / 1ps

module tisd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	logic accept;

	// the stage frees up in the same cycle the core takes its item
	assign s_tready = !valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

// ===== rtl/core/tisd_wrap.sv =====
`timescale 1ns / 1ps

module tisd_wrap (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [16:0]          dividend,
	input  logic [15:0]          divisor,
	output tisd_pkg::tisd_wrap_t res
);

	logic        busy_q;
	logic        step_q;
	logic [16:0] rem_q;
	logic [15:0] div_q;
	logic [3:0]  q_hi_q;
	logic [22:0] den;
	logic [22:0] trial;
	logic [16:0] r;
	logic [3:0]  nib;

	// four restoring steps per cycle: quotient bits 7..4, then 3..0
	always_comb begin
		den = step_q ? {7'd0, div_q} : {3'd0, div_q, 4'd0};
		r   = rem_q;
		nib = 4'd0;
		for (int i = 3; i >= 0; i--) begin
			trial = den << i;
			if ({6'd0, r} >= trial) begin
				r      = r - trial[16:0];
				nib[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			rem_q  <= '0;
			div_q  <= '0;
			q_hi_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 1'b0;
			rem_q  <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			if (step_q) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= 1'b1;
				rem_q  <= r;
				q_hi_q <= nib;
			end
		end
	end

	assign res.valid = busy_q && step_q;
	assign res.busy  = busy_q;
	assign res.quot  = {q_hi_q, nib};
	assign res.rem   = r[15:0];

endmodule

// ===== rtl/core/tisd_core.sv =====
`timescale 1ns / 1ps

module tisd_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s1,
	input  logic [7:0]             byte_s1,
	input  logic                   last_s1,
	output logic                   take,
	input  logic                   m_tready,
	output logic                   out_valid_q,
	output tisd_pkg::tisd_result_t res_q
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ID,
		PH_MAP,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE,
		PH_HALT
	} phase_t;

	// header byte offsets
	localparam logic [7:0] OFS_ID_LEN  = 8'd0;
	localparam logic [7:0] OFS_TYPE    = 8'd2;
	localparam logic [7:0] OFS_MAP_LO  = 8'd5;
	localparam logic [7:0] OFS_MAP_HI  = 8'd6;
	localparam logic [7:0] OFS_MAP_BPE = 8'd7;
	localparam logic [7:0] OFS_W_LO    = 8'd12;
	localparam logic [7:0] OFS_W_HI    = 8'd13;
	localparam logic [7:0] OFS_H_LO    = 8'd14;
	localparam logic [7:0] OFS_H_HI    = 8'd15;
	localparam logic [7:0] OFS_BPP     = 8'd16;
	localparam logic [7:0] OFS_DESC    = 8'd17;

	phase_t      phase_q, phase_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  id_len_q, id_len_n;
	logic [7:0]  type_q, type_n;
	logic        comp_q, comp_n;
	logic [15:0] map_len_q, map_len_n;
	logic [4:0]  map_bpe_q, map_bpe_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic [4:0]  bpp_q, bpp_n;
	logic        top_q, top_n;
	logic [15:0] map_cnt_q, map_cnt_n;
	logic [23:0] pix_q, pix_n;
	logic [7:0]  pkt_rem_q, pkt_rem_n;
	logic        pkt_rep_q, pkt_rep_n;
	logic [15:0] row_q, row_n;
	logic [15:0] col_q, col_n;
	logic [31:0] left_q, left_n;
	logic [31:0] area_q;

	tisd_pkg::tisd_result_t res;
	tisd_pkg::tisd_rgb_t    rgb;
	tisd_pkg::tisd_wrap_t   wrap;
	logic        have;
	logic        do_after_id;
	logic        do_start;
	logic        from_id;
	logic        stall;
	logic        div_start;
	logic [16:0] div_dividend;
	logic [23:0] pix_acc;
	logic [7:0]  n_raw;
	logic [7:0]  n;
	logic [16:0] col_inc;

	// pixel bytes wait while a run's row/column wrap is still being worked out
	assign stall = wrap.busy && (phase_q == PH_PIXEL);
	assign take  = valid_s1 && (!out_valid_q || m_tready) && !stall;

	// image area for the pixel countdown
	always_ff @(posedge clk) begin
		area_q <= width_q * height_q;
	end

	tisd_wrap u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start && take),
		.dividend (div_dividend),
		.divisor  (width_q),
		.res      (wrap)
	);

	// next state and result for the item in the input stage
	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		id_len_n  = id_len_q;
		type_n    = type_q;
		comp_n    = comp_q;
		map_len_n = map_len_q;
		map_bpe_n = map_bpe_q;
		width_n   = width_q;
		height_n  = height_q;
		bpp_n     = bpp_q;
		top_n     = top_q;
		map_cnt_n = map_cnt_q;
		pix_n     = pix_q;
		pkt_rem_n = pkt_rem_q;
		pkt_rep_n = pkt_rep_q;
		row_n     = row_q;
		col_n     = col_q;
		left_n    = left_q;
		res       = '0;
		rgb       = '0;
		have      = 1'b0;
		do_after_id  = 1'b0;
		do_start     = 1'b0;
		from_id      = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		n_raw        = 8'd1;
		n            = 8'd1;
		col_inc      = {1'b0, col_q} + 17'd1;

		// new byte merged into the bytes gathered so far
		pix_acc = pix_q;
		case (cnt_q[1:0])
			2'd0:    pix_acc[7:0]   = byte_s1;
			2'd1:    pix_acc[15:8]  = byte_s1;
			2'd2:    pix_acc[23:16] = byte_s1;
			default: pix_acc        = pix_q;
		endcase

		case (phase_q)
			PH_HEADER: begin
				case (cnt_q)
					OFS_ID_LEN:  id_len_n  = byte_s1;
					OFS_TYPE:    type_n    = byte_s1;
					OFS_MAP_LO:  map_len_n = {8'd0, byte_s1};
					OFS_MAP_HI:  map_len_n = {byte_s1, map_len_q[7:0]};
					OFS_MAP_BPE: map_bpe_n = byte_s1[7:3];
					OFS_W_LO:    width_n   = {8'd0, byte_s1};
					OFS_W_HI:    width_n   = {byte_s1, width_q[7:0]};
					OFS_H_LO:    height_n  = {8'd0, byte_s1};
					OFS_H_HI:    height_n  = {byte_s1, height_q[7:0]};
					OFS_BPP:     bpp_n     = byte_s1[7:3];
					OFS_DESC:    top_n     = byte_s1[5];
					default:     cnt_n     = cnt_q + 8'd1;
				endcase
				cnt_n = cnt_q + 8'd1;
				if (cnt_q == OFS_DESC) begin
					cnt_n = 8'd0;
					if (type_q >= 8'd1 && type_q <= 8'd3) begin
						comp_n = 1'b0;
					end else if (type_q >= 8'd9 && type_q <= 8'd11) begin
						comp_n = 1'b1;
					end else begin
						res.kind   = tisd_pkg::KIND_STATUS;
						res.status = tisd_pkg::ST_BAD_TYPE;
						have       = 1'b1;
						phase_n    = PH_HALT;
					end
					if (!have) begin
						if (id_len_q != 8'd0) begin
							phase_n = PH_ID;
						end else begin
							do_after_id = 1'b1;
						end
					end
				end
			end
			PH_ID: begin
				cnt_n = cnt_q + 8'd1;
				if (cnt_n >= id_len_q) begin
					cnt_n       = 8'd0;
					do_after_id = 1'b1;
				end
			end
			PH_MAP: begin
				pix_n = pix_acc;
				cnt_n = cnt_q + 8'd1;
				if (cnt_n >= {3'd0, map_bpe_q}) begin
					rgb           = tisd_pkg::tisd_to_rgb(map_bpe_q, pix_acc);
					res.kind      = tisd_pkg::KIND_MAP;
					res.map_entry = map_cnt_q;
					res.red       = rgb.red;
					res.green     = rgb.green;
					res.blue      = rgb.blue;
					have          = 1'b1;
					cnt_n         = 8'd0;
					pix_n         = '0;
					map_cnt_n     = map_cnt_q + 16'd1;
					if (map_cnt_n >= map_len_q) begin
						do_start = 1'b1;
					end
				end
			end
			PH_PACKET, PH_PIXEL: begin
				if (map_len_q == 16'd0 && (bpp_q == 5'd0 || bpp_q > 5'd4)) begin
					res.kind   = tisd_pkg::KIND_STATUS;
					res.status = tisd_pkg::ST_PIX_SIZE;
					have       = 1'b1;
					phase_n    = PH_HALT;
				end else if (phase_q == PH_PACKET) begin
					pkt_rep_n = byte_s1[7];
					pkt_rem_n = {1'b0, byte_s1[6:0]} + 8'd1;
					phase_n   = PH_PIXEL;
					cnt_n     = 8'd0;
					pix_n     = '0;
				end else begin
					pix_n = pix_acc;
					cnt_n = cnt_q + 8'd1;
					if (cnt_n >= {3'd0, bpp_q}) begin
						cnt_n = 8'd0;
						pix_n = '0;
						// run length, clipped to the pixels left in the image
						n_raw = (comp_q && pkt_rep_q) ? pkt_rem_q : 8'd1;
						n     = (left_q < {24'd0, n_raw}) ? left_q[7:0] : n_raw;
						if (map_len_q != 16'd0) begin
							res.kind        = tisd_pkg::KIND_INDEX;
							res.color_index = pix_acc[7:0];
						end else begin
							rgb       = tisd_pkg::tisd_to_rgb(bpp_q, pix_acc);
							res.kind  = tisd_pkg::KIND_RGB;
							res.red   = rgb.red;
							res.green = rgb.green;
							res.blue  = rgb.blue;
						end
						res.row        = top_q ? row_q : (height_q - 16'd1 - row_q);
						res.column     = col_q;
						res.run_length = n;
						res.top_first  = top_q;
						have           = 1'b1;
						left_n         = left_q - {24'd0, n};
						// single pixel steps wrap here, repeat runs go to the wrap unit
						if (comp_q && pkt_rep_q) begin
							pkt_rem_n = 8'd0;
							phase_n   = PH_PACKET;
							if (left_n != 32'd0) begin
								div_start    = 1'b1;
								div_dividend = {1'b0, col_q} + {9'd0, n};
							end
						end else begin
							if (col_inc == {1'b0, width_q}) begin
								col_n = 16'd0;
								row_n = row_q + 16'd1;
							end else begin
								col_n = col_inc[15:0];
							end
							if (comp_q) begin
								pkt_rem_n = pkt_rem_q - 8'd1;
								if (pkt_rem_n == 8'd0) begin
									phase_n = PH_PACKET;
								end
							end
						end
						if (left_n == 32'd0) begin
							phase_n        = PH_DONE;
							res.image_done = 1'b1;
						end
					end
				end
			end
			default: begin
				have = 1'b0;
			end
		endcase

		// checks once the id field is behind
		if (do_after_id) begin
			if (map_len_q != 16'd0) begin
				if (bpp_q != 5'd1) begin
					res.kind   = tisd_pkg::KIND_STATUS;
					res.status = tisd_pkg::ST_MAP_INDEX;
					have       = 1'b1;
					phase_n    = PH_HALT;
				end else if (map_bpe_q == 5'd0 || map_bpe_q > 5'd4) begin
					res.kind   = tisd_pkg::KIND_STATUS;
					res.status = tisd_pkg::ST_PIX_SIZE;
					have       = 1'b1;
					phase_n    = PH_HALT;
				end else begin
					phase_n   = PH_MAP;
					map_cnt_n = 16'd0;
					cnt_n     = 8'd0;
					pix_n     = '0;
				end
			end else begin
				do_start = 1'b1;
				from_id  = 1'b1;
			end
		end

		// pixel data begins
		if (do_start) begin
			row_n  = 16'd0;
			col_n  = 16'd0;
			cnt_n  = 8'd0;
			pix_n  = '0;
			left_n = area_q;
			if (width_q == 16'd0 || height_q == 16'd0) begin
				phase_n = PH_DONE;
				if (from_id) begin
					res      = '0;
					res.kind = tisd_pkg::KIND_STATUS;
					have     = 1'b1;
				end
				res.image_done = 1'b1;
			end else begin
				phase_n = comp_n ? PH_PACKET : PH_PIXEL;
			end
		end

		// file ends before the image does
		if (last_s1 && phase_n != PH_DONE && phase_n != PH_HALT) begin
			if (!have) begin
				res      = '0;
				res.kind = tisd_pkg::KIND_STATUS;
				have     = 1'b1;
			end
			res.status = tisd_pkg::ST_EARLY_END;
			phase_n    = PH_HALT;
		end

		// finished or halted: bytes are dropped
		if (phase_q == PH_DONE || phase_q == PH_HALT) begin
			phase_n   = phase_q;
			have      = 1'b0;
			div_start = 1'b0;
		end
	end

	// decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cnt_q       <= '0;
			id_len_q    <= '0;
			type_q      <= '0;
			comp_q      <= 1'b0;
			map_len_q   <= '0;
			map_bpe_q   <= '0;
			width_q     <= '0;
			height_q    <= '0;
			bpp_q       <= '0;
			top_q       <= 1'b0;
			map_cnt_q   <= '0;
			pix_q       <= '0;
			pkt_rem_q   <= '0;
			pkt_rep_q   <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				phase_q   <= phase_n;
				cnt_q     <= cnt_n;
				id_len_q  <= id_len_n;
				type_q    <= type_n;
				comp_q    <= comp_n;
				map_len_q <= map_len_n;
				map_bpe_q <= map_bpe_n;
				width_q   <= width_n;
				height_q  <= height_n;
				bpp_q     <= bpp_n;
				top_q     <= top_n;
				map_cnt_q <= map_cnt_n;
				pix_q     <= pix_n;
				pkt_rem_q <= pkt_rem_n;
				pkt_rep_q <= pkt_rep_n;
				left_q    <= left_n;
			end
			// a repeat run's wrap lands while only packet bytes can be taken
			if (wrap.valid) begin
				row_q <= row_q + {8'd0, wrap.quot};
				col_q <= wrap.rem;
			end else if (take) begin
				row_q <= row_n;
				col_q <= col_n;
			end
			if (take && have) begin
				out_valid_q <= 1'b1;
				res_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// nothing is produced once the image is finished or the block halted
	a_no_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (phase_q == PH_DONE || phase_q == PH_HALT)) |=> $stable(res_q))
		else $error("result produced after end of image");

	// a wrap computation never restarts before the previous one lands
	a_wrap_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		(take && div_start) |-> !wrap.busy)
		else $error("wrap unit started while busy");

	// pixel phases always have pixels left to place
	a_pixels_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PACKET || phase_q == PH_PIXEL) |-> (left_q != 32'd0))
		else $error("pixel phase with no pixels left");

	// completing result is never an error
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(take && have && res.image_done) |-> (res.status == tisd_pkg::ST_OK))
		else $error("image completed with an error status");

	// a wrap result never coincides with a pixel byte being placed
	a_wrap_vs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		wrap.valid |-> !(take && phase_q == PH_PIXEL))
		else $error("pixel placed while its position was pending");
`endif

endmodule

// ===== rtl/core/targa_image_stream_decoder.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake         tdata                          tuser       tlast
// s_*       in   s_tvalid/tready   [7:0] data_byte                -           last_byte
// m_*       out  m_tvalid/tready   92 bits of result, see port    [1:0] kind  image_done
//
// One byte is taken per cycle unless the output or the wrap unit stalls; its result, if any, is registered.
// An input stage register and the result register sit on either side of the decoder.
// An RLE repeat run is wrapped to row/column by the tisd_wrap divide unit;
// a pixel byte arriving right behind the packet header after a repeat run may wait on it.
// Reset (arst_n low) returns the decoder to the start of a header and empties both stages.
// A stall on m_tready holds the result and, once the input stage fills, s_tready.

module targa_image_stream_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tisd_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // last_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] map_entry, [23:16] color_index, [31:24] red, [39:32] green,
	// [47:40] blue, [63:48] row, [79:64] column, [87:80] run_length,
	// [88] top_first, [91:89] status, [95:92] zero
	output logic [tisd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [tisd_pkg::OUT_USER_W-1:0]     m_tuser,   // [1:0] kind
	output logic                                m_tlast    // image_done
);

	logic                   take;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	tisd_pkg::tisd_result_t res_q;

	tisd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	tisd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.last_s1     (last_s1),
		.take        (take),
		.m_tready    (m_tready),
		.out_valid_q (m_tvalid),
		.res_q       (res_q)
	);

	// result packing
	assign m_tdata = {4'd0, res_q.status, res_q.top_first, res_q.run_length, res_q.column,
		res_q.row, res_q.blue, res_q.green, res_q.red, res_q.color_index, res_q.map_entry};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.image_done;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// image type codes accepted by the decoder
	localparam logic [7:0] TGA_RAW_FIRST  = 8'd1;
	localparam logic [7:0] TGA_RAW_LAST   = 8'd3;
	localparam logic [7:0] TGA_RLE_FIRST  = 8'd9;
	localparam logic [7:0] TGA_RLE_MAPPED = 8'd9;
	localparam logic [7:0] TGA_RLE_LAST   = 8'd11;

	localparam int DIR_ROWS   = 25;
	localparam int RAND_ITEMS = 500;
	localparam int MAX_ITEMS  = 4000;
	localparam int TAIL_WAIT  = 20;

	typedef enum logic [2:0] {
		DEC_HEADER, DEC_ID, DEC_MAP, DEC_PACKET, DEC_PIXEL, DEC_DONE, DEC_HALT
	} dec_phase_t;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	typedef struct {
		logic [7:0]             data;
		logic                   last;
		bit                     typed;
		tisd_pkg::tisd_result_t want;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [tisd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [tisd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [tisd_pkg::OUT_USER_W-1:0] m_tuser;
	logic                            m_tlast;

	targa_image_stream_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// decoder shadow state
	dec_phase_t  ph = DEC_HEADER;
	logic [7:0]  pos = '0;
	logic [7:0]  id_len = '0;
	logic [7:0]  img_type = '0;
	logic        rle = 1'b0;
	logic [15:0] map_len = '0;
	logic [4:0]  map_size = '0;
	logic [15:0] img_w = '0;
	logic [15:0] img_h = '0;
	logic [4:0]  pix_size = '0;
	logic        top = 1'b0;
	logic [15:0] map_idx = '0;
	logic [31:0] acc = '0;
	logic [7:0]  pkt_left = '0;
	logic        pkt_rep = 1'b0;
	logic [15:0] row_cnt = '0;
	logic [15:0] col_cnt = '0;

	tisd_pkg::tisd_result_t pending_results[$];
	int unsigned  err_count = 0;
	int unsigned  burst_left = 0;
	rx_mode_t     rx_mode = RX_OPEN;
	int unsigned  rx_left = 0;
	stim_row_t    dir_tab [DIR_ROWS];

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("tb: errors");
		$finish;
	end

	task automatic flag_error(input string msg);
		err_count++;
		$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	// color widening for 1, 2 and 3/4 byte values, low byte first
	function automatic logic [23:0] widen_color(input logic [4:0] size, input logic [31:0] v);
		if (size == 5'd1)
			return {v[7:0], v[7:0], v[7:0]};
		if (size == 5'd2)
			return {v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
		return v[23:0];
	endfunction

	function automatic bit begin_pixels();
		row_cnt = '0;
		col_cnt = '0;
		pos = '0;
		acc = '0;
		if (img_w == 16'd0 || img_h == 16'd0) begin
			ph = DEC_DONE;
			return 1'b1;
		end
		ph = rle ? DEC_PACKET : DEC_PIXEL;
		return 1'b0;
	endfunction

	// checks that follow the id field, or the header when there is none
	task automatic leave_id(inout bit have, inout tisd_pkg::tisd_result_t r);
		if (map_len != 16'd0) begin
			if (pix_size != 5'd1) begin
				r.kind = tisd_pkg::KIND_STATUS;
				r.status = tisd_pkg::ST_MAP_INDEX;
				ph = DEC_HALT;
				have = 1'b1;
			end else if (map_size == 5'd0 || map_size > 5'd4) begin
				r.kind = tisd_pkg::KIND_STATUS;
				r.status = tisd_pkg::ST_PIX_SIZE;
				ph = DEC_HALT;
				have = 1'b1;
			end else begin
				ph = DEC_MAP;
				map_idx = '0;
				pos = '0;
				acc = '0;
			end
		end else if (begin_pixels()) begin
			r.kind = tisd_pkg::KIND_STATUS;
			r.image_done = 1'b1;
			have = 1'b1;
		end
	endtask

	// place a run of pixels, clipped to what is left of the image
	task automatic place_run(input int unsigned n, inout tisd_pkg::tisd_result_t r);
		longint unsigned room;
		int unsigned     cnt;
		int unsigned     total;
		room = (64'(img_h) - 64'(row_cnt) - 64'd1) * 64'(img_w) + 64'(img_w) - 64'(col_cnt);
		cnt = (64'(n) > room) ? 32'(room) : n;
		if (map_len != 16'd0) begin
			r.kind = tisd_pkg::KIND_INDEX;
			r.color_index = acc[7:0];
		end else begin
			r.kind = tisd_pkg::KIND_RGB;
			{r.red, r.green, r.blue} = widen_color(pix_size, acc);
		end
		r.row = top ? row_cnt : img_h - 16'd1 - row_cnt;
		r.column = col_cnt;
		r.run_length = cnt[7:0];
		r.top_first = top;
		total = 32'(col_cnt) + cnt;
		row_cnt = row_cnt + 16'(total / 32'(img_w));
		col_cnt = 16'(total % 32'(img_w));
		if (row_cnt >= img_h) begin
			ph = DEC_DONE;
			r.image_done = 1'b1;
		end
	endtask

	// expected result of one accepted file byte
	task automatic decode_byte(input logic [7:0] b, input logic last, output bit have,
			output tisd_pkg::tisd_result_t r);
		have = 1'b0;
		r = '0;
		if (ph != DEC_DONE && ph != DEC_HALT) begin
			case (ph)
				DEC_HEADER: begin
					// fixed 18-byte header, offsets from its first byte
					case (pos)
						8'd0:  id_len = b;
						8'd2:  img_type = b;
						8'd5:  map_len = {8'd0, b};
						8'd6:  map_len[15:8] = b;
						8'd7:  map_size = b[7:3];
						8'd12: img_w = {8'd0, b};
						8'd13: img_w[15:8] = b;
						8'd14: img_h = {8'd0, b};
						8'd15: img_h[15:8] = b;
						8'd16: pix_size = b[7:3];
						8'd17: top = b[5];
						default: ;
					endcase
					if (pos != 8'd17) begin
						pos = pos + 8'd1;
					end else begin
						pos = '0;
						if (img_type >= TGA_RAW_FIRST && img_type <= TGA_RAW_LAST) begin
							rle = 1'b0;
						end else if (img_type >= TGA_RLE_FIRST && img_type <= TGA_RLE_LAST) begin
							rle = 1'b1;
						end else begin
							r.kind = tisd_pkg::KIND_STATUS;
							r.status = tisd_pkg::ST_BAD_TYPE;
							ph = DEC_HALT;
							have = 1'b1;
						end
						if (!have) begin
							if (id_len != 8'd0)
								ph = DEC_ID;
							else
								leave_id(have, r);
						end
					end
				end
				DEC_ID: begin
					pos = pos + 8'd1;
					if (pos >= id_len) begin
						pos = '0;
						leave_id(have, r);
					end
				end
				DEC_MAP: begin
					acc = acc | (32'(b) << (8 * pos[1:0]));
					pos = pos + 8'd1;
					if (pos >= 8'(map_size)) begin
						r.kind = tisd_pkg::KIND_MAP;
						r.map_entry = map_idx;
						{r.red, r.green, r.blue} = widen_color(map_size, acc);
						pos = '0;
						acc = '0;
						map_idx = map_idx + 16'd1;
						if (map_idx >= map_len && begin_pixels())
							r.image_done = 1'b1;
						have = 1'b1;
					end
				end
				default: begin
					// packet header or pixel bytes
					if (map_len == 16'd0 && (pix_size == 5'd0 || pix_size > 5'd4)) begin
						r.kind = tisd_pkg::KIND_STATUS;
						r.status = tisd_pkg::ST_PIX_SIZE;
						ph = DEC_HALT;
						have = 1'b1;
					end else if (ph == DEC_PACKET) begin
						pkt_rep = b[7];
						pkt_left = {1'b0, b[6:0]} + 8'd1;
						ph = DEC_PIXEL;
						pos = '0;
						acc = '0;
					end else begin
						acc = acc | (32'(b) << (8 * pos[1:0]));
						pos = pos + 8'd1;
						if (pos >= 8'(pix_size)) begin
							pos = '0;
							if (!rle) begin
								place_run(1, r);
							end else if (pkt_rep) begin
								place_run(32'(pkt_left), r);
								pkt_left = '0;
								if (ph != DEC_DONE)
									ph = DEC_PACKET;
							end else begin
								place_run(1, r);
								pkt_left = pkt_left - 8'd1;
								if (ph != DEC_DONE && pkt_left == 8'd0)
									ph = DEC_PACKET;
							end
							acc = '0;
							have = 1'b1;
						end
					end
				end
			endcase
			// file ended before the image was complete
			if (last && ph != DEC_DONE && ph != DEC_HALT) begin
				if (!have) begin
					r = '0;
					r.kind = tisd_pkg::KIND_STATUS;
					have = 1'b1;
				end
				r.status = tisd_pkg::ST_EARLY_END;
				ph = DEC_HALT;
			end
		end
	endtask

	// send one item in bursts; called and returns just after a falling edge
	task automatic push_byte(input logic [7:0] d, input logic l, input bit typed,
			input tisd_pkg::tisd_result_t want);
		bit                     have;
		tisd_pkg::tisd_result_t r;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(d, l, have, r);
		if (have)
			pending_results.push_back(typed ? want : r);
		burst_left--;
		@(negedge clk);
	endtask

	// hold off the sender until every expected result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// mostly short literal runs, some repeats, now and then a long one
	function automatic logic [7:0] packet_header();
		int unsigned n;
		if ($urandom_range(0, 9) < 6) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
			return {1'b0, 7'(n - 1)};
		end
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
		return {1'b1, 7'(n - 1)};
	endfunction

	function automatic stim_row_t plain(input logic [7:0] d);
		stim_row_t s;
		s.data = d;
		s.last = 1'b0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic stim_row_t map_row(input logic [7:0] d, input logic [15:0] e,
			input logic [23:0] rgb);
		stim_row_t s;
		s = plain(d);
		s.typed = 1'b1;
		s.want.kind = tisd_pkg::KIND_MAP;
		s.want.map_entry = e;
		{s.want.red, s.want.green, s.want.blue} = rgb;
		s.want.status = tisd_pkg::ST_OK;
		return s;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= ~m_tready;
		endcase
	end

	// compare each item on the output against the oldest expectation
	always @(posedge clk) begin
		tisd_pkg::tisd_result_t got;
		tisd_pkg::tisd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.map_entry = m_tdata[15:0];
			got.color_index = m_tdata[23:16];
			got.red = m_tdata[31:24];
			got.green = m_tdata[39:32];
			got.blue = m_tdata[47:40];
			got.row = m_tdata[63:48];
			got.column = m_tdata[79:64];
			got.run_length = m_tdata[87:80];
			got.top_first = m_tdata[88];
			got.status = m_tdata[91:89];
			got.image_done = m_tlast;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result with nothing pending, kind %0d", got.kind));
			end else begin
				want = pending_results.pop_front();
				compare_field("kind", 16'(got.kind), 16'(want.kind));
				compare_field("map_entry", got.map_entry, want.map_entry);
				compare_field("color_index", 16'(got.color_index), 16'(want.color_index));
				compare_field("red", 16'(got.red), 16'(want.red));
				compare_field("green", 16'(got.green), 16'(want.green));
				compare_field("blue", 16'(got.blue), 16'(want.blue));
				compare_field("row", got.row, want.row);
				compare_field("column", got.column, want.column);
				compare_field("run_length", 16'(got.run_length), 16'(want.run_length));
				compare_field("top_first", 16'(got.top_first), 16'(want.top_first));
				compare_field("status", 16'(got.status), 16'(want.status));
				compare_field("image_done", 16'(got.image_done), 16'(want.image_done));
			end
		end
	end

	// stimulus
	initial begin
		int unsigned sent;
		int unsigned pause_at;
		bit          run_to_end;
		bit          fin;
		logic [7:0]  d;

		// colour-mapped rle file, bottom-first, three 16-bit map entries
		dir_tab[0]  = plain(8'd1);            // id field length
		dir_tab[1]  = plain(8'd1);            // map present
		dir_tab[2]  = plain(TGA_RLE_MAPPED);
		dir_tab[3]  = plain(8'h00);           // first map entry
		dir_tab[4]  = plain(8'h00);
		dir_tab[5]  = plain(8'd3);            // map length
		dir_tab[6]  = plain(8'h00);
		dir_tab[7]  = plain(8'd16);           // map entry bits
		dir_tab[8]  = plain(8'hff);           // x origin, unused
		dir_tab[9]  = plain(8'hff);
		dir_tab[10] = plain(8'h00);           // y origin, unused
		dir_tab[11] = plain(8'h00);
		dir_tab[12] = plain(8'h05);           // width 261
		dir_tab[13] = plain(8'h01);
		dir_tab[14] = plain(8'h04);           // height 4
		dir_tab[15] = plain(8'h00);
		dir_tab[16] = plain(8'd8);            // 8-bit indices
		dir_tab[17] = plain(8'h08);           // bottom-first, alpha bits
		dir_tab[18] = plain(8'ha5);           // id byte
		dir_tab[19] = plain(8'hff);
		dir_tab[20] = map_row(8'hff, 16'd0, 24'hf8f8f8);
		dir_tab[21] = plain(8'h00);
		dir_tab[22] = map_row(8'h00, 16'd1, 24'h000000);
		dir_tab[23] = plain(8'he0);
		dir_tab[24] = map_row(8'h83, 16'd2, 24'h00f800);

		// reset
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		for (int i = 0; i < DIR_ROWS; i++)
			push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
		drain_results();

		// random packets, either to the end of the image or cut short
		run_to_end = 1'($urandom_range(0, 1));
		pause_at = $urandom_range(100, 400);
		sent = 0;
		while (ph != DEC_DONE && ph != DEC_HALT) begin
			if (sent == pause_at)
				drain_results();
			fin = (!run_to_end && sent >= RAND_ITEMS) || sent >= MAX_ITEMS;
			d = (ph == DEC_PACKET) ? packet_header() : 8'($urandom_range(0, 255));
			push_byte(d, fin, 1'b0, '0);
			sent++;
		end

		// bytes after the image are ignored
		repeat ($urandom_range(3, 12))
			push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
